/* rtl/amap_pkg.sv */
package amap_pkg;

	localparam int unsigned ARRAYS_DEF   = 16;
	localparam int unsigned MAX_DIMS_DEF = 10;

	localparam int unsigned IN_DATA_W  = 160;
	localparam int unsigned OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_BOUNDS = 2'd1,
		CMD_REF    = 2'd2,
		CMD_NONE   = 2'd3
	} amap_cmd_t;

	typedef struct packed {
		logic hdr_we;
		logic dim_we;
		logic rd_en;
	} amap_tbl_ctl_t;

endpackage

/* rtl/amap_tables.sv */
module amap_tables
	import amap_pkg::*;
#(
	parameter int unsigned ARRAYS   = ARRAYS_DEF,
	parameter int unsigned MAX_DIMS = MAX_DIMS_DEF,
	localparam int unsigned AW = (ARRAYS > 1) ? $clog2(ARRAYS) : 1,
	localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
	input  logic          clk,
	input  amap_tbl_ctl_t ctl,
	input  logic [AW-1:0] hdr_addr,
	input  logic [DW-1:0] dim_addr,
	input  logic [31:0]   base_wr,
	input  logic [15:0]   size_wr,
	input  logic [31:0]   lower_wr,
	input  logic [31:0]   upper_wr,
	output logic [31:0]   base_rd,
	output logic [15:0]   size_rd,
	output logic [31:0]   lower_rd,
	output logic [31:0]   extent_rd
);

	localparam int unsigned DIM_DEPTH = ARRAYS * (2 ** DW);

	logic [47:0] hdr_mem [ARRAYS];
	logic [63:0] dim_mem [DIM_DEPTH];

	logic [AW+DW-1:0] row;
	assign row = {hdr_addr, dim_addr};

	always_ff @(posedge clk) begin
		if (ctl.hdr_we) begin
			hdr_mem[hdr_addr] <= {size_wr, base_wr};
		end
		if (ctl.dim_we) begin
			dim_mem[row] <= {upper_wr - lower_wr + 32'd1, lower_wr};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			{size_rd, base_rd}    <= hdr_mem[hdr_addr];
			{extent_rd, lower_rd} <= dim_mem[row];
		end
	end

endmodule

/* rtl/multidim_array_address_mapper_core.sv */
// Channel  Dir  tdata                          tuser      tlast
// s_axis   in   descriptor or index (160 bits)  cmd (2)    last_index
// m_axis   out  phys_addr, ref_array (40 bits)  -          -
//
// Header and bound items are written as they are taken. A non-final index
// steps through table read, multiply by extent and add of (index - lower),
// with the arithmetic on the one shared 32x32 multiplier and adder. A final
// index goes on: the same multiplier scales by element size, and the base is added.
// Reset clears the sequencer, running offset and dimension count; tables are
// not cleared. A waiting result does not block input; a second result waits
// in the last step until the output register is free.
module multidim_array_address_mapper_core
	import amap_pkg::*;
#(
	parameter int unsigned ARRAYS   = ARRAYS_DEF,
	parameter int unsigned MAX_DIMS = MAX_DIMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// array_id, dim_pos, base_addr, elem_size, num_dims, lower_bound,
	// upper_bound, index_value, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic [1:0]            s_axis_tuser,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// phys_addr, ref_array, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int unsigned AW = (ARRAYS > 1) ? $clog2(ARRAYS) : 1;
	localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_SCALE,
		S_SUM
	} state_t;

	state_t        state_q;
	logic [31:0]   acc_q;
	logic [31:0]   prod_q;
	logic [DW-1:0] next_dim_q;
	logic          id_ok_q;
	logic          last_q;
	logic [3:0]    id_q;
	logic [31:0]   idx_q;
	logic          out_valid_q;
	logic [31:0]   out_addr_q;
	logic [3:0]    out_id_q;

	logic [3:0]  in_id;
	logic [3:0]  in_dpos;
	logic [31:0] in_base;
	logic [15:0] in_size;
	logic [31:0] in_lower;
	logic [31:0] in_upper;
	logic [31:0] in_index;
	amap_cmd_t   in_cmd;

	assign in_id    = s_axis_tdata[3:0];
	assign in_dpos  = s_axis_tdata[7:4];
	assign in_base  = s_axis_tdata[39:8];
	assign in_size  = s_axis_tdata[55:40];
	assign in_lower = s_axis_tdata[91:60];
	assign in_upper = s_axis_tdata[123:92];
	assign in_index = s_axis_tdata[155:124];
	assign in_cmd   = amap_cmd_t'(s_axis_tuser);

	logic accept;
	logic id_ok;
	logic dpos_ok;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign id_ok         = 32'(in_id) < ARRAYS;
	assign dpos_ok       = 32'(in_dpos) < MAX_DIMS;

	amap_tbl_ctl_t tbl_ctl;
	logic [DW-1:0] dim_addr;
	logic [31:0]   base_rd;
	logic [15:0]   size_rd;
	logic [31:0]   lower_rd;
	logic [31:0]   extent_rd;

	assign tbl_ctl.hdr_we = accept && (in_cmd == CMD_HEADER) && id_ok;
	assign tbl_ctl.dim_we = accept && (in_cmd == CMD_BOUNDS) && id_ok && dpos_ok;
	assign tbl_ctl.rd_en  = accept && (in_cmd == CMD_REF);
	assign dim_addr = (in_cmd == CMD_BOUNDS) ? DW'(in_dpos) : next_dim_q;

	amap_tables #(
		.ARRAYS   (ARRAYS),
		.MAX_DIMS (MAX_DIMS)
	) u_tables (
		.clk       (clk),
		.ctl       (tbl_ctl),
		.hdr_addr  (AW'(in_id)),
		.dim_addr  (dim_addr),
		.base_wr   (in_base),
		.size_wr   (in_size),
		.lower_wr  (in_lower),
		.upper_wr  (in_upper),
		.base_rd   (base_rd),
		.size_rd   (size_rd),
		.lower_rd  (lower_rd),
		.extent_rd (extent_rd)
	);

	// out-of-range id reads as zero
	logic [31:0] base_m, size_m, lower_m, extent_m;
	assign base_m   = id_ok_q ? base_rd : '0;
	assign size_m   = id_ok_q ? 32'(size_rd) : '0;
	assign lower_m  = id_ok_q ? lower_rd : '0;
	assign extent_m = id_ok_q ? extent_rd : '0;

	// shared multiplier and adder
	logic [31:0] mul_b, mul_p, add_a, add_b, add_s;
	assign mul_b = (state_q == S_MUL) ? extent_m : size_m;
	assign mul_p = acc_q * mul_b;
	assign add_a = prod_q;
	assign add_b = (state_q == S_ACC) ? (idx_q - lower_m) : base_m;
	assign add_s = add_a + add_b;

	logic out_free;
	logic load_out;
	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = (state_q == S_SUM) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			next_dim_q  <= '0;
			out_valid_q <= 1'b0;
			prod_q      <= '0;
			id_ok_q     <= 1'b0;
			last_q      <= 1'b0;
			id_q        <= '0;
			idx_q       <= '0;
			out_addr_q  <= '0;
			out_id_q    <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (in_cmd == CMD_REF)) begin
						id_ok_q <= id_ok;
						last_q  <= s_axis_tlast;
						id_q    <= in_id;
						idx_q   <= in_index;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= add_s;
					if (last_q) begin
						state_q <= S_SCALE;
					end else begin
						if (32'(next_dim_q) != MAX_DIMS - 1) begin
							next_dim_q <= next_dim_q + DW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_SCALE: begin
					prod_q  <= mul_p;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (out_free) begin
						out_addr_q  <= add_s;
						out_id_q    <= id_q;
						acc_q       <= '0;
						next_dim_q  <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_id_q, out_addr_q};

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(next_dim_q) < MAX_DIMS)
		else $error("dimension counter beyond last dimension");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (acc_q == '0) && (next_dim_q == '0) && m_axis_tvalid)
		else $error("reference state not cleared after result");

	a_busy_after_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_cmd == CMD_REF)) |=> !s_axis_tready)
		else $error("input taken while an index is in work");

endmodule

/* dv/tb_multidim_array_address_mapper_core.sv */
`timescale 1ns / 100ps

module tb_multidim_array_address_mapper_core;
	import amap_pkg::*;

	localparam int N_ARR       = ARRAYS_DEF;
	localparam int N_DIMS      = MAX_DIMS_DEF;
	localparam int ITEMS       = 1650;
	localparam int SQUEEZE_CYC = 400;
	localparam int DRAIN_CYC   = 40;
	localparam int LIMIT_CYC   = 400000;

	localparam int PH_CALM     = 0;
	localparam int PH_SRC_IDLE = 1;
	localparam int PH_SINK     = 2;
	localparam int PH_BOTH     = 3;
	localparam int PH_SQUEEZE  = 4;

	typedef struct packed {
		amap_cmd_t   cmd;
		logic [3:0]  id;
		logic [3:0]  dpos;
		logic [31:0] base;
		logic [15:0] size;
		logic [3:0]  ndims;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] idx;
		logic        last;
		logic        typed;
		logic [31:0] want;
	} map_row_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [3:0]  arr;
	} addr_exp_t;

	// cmd, id, dim, base, size, ndims, lower, upper, index, last, typed, expected address
	localparam map_row_t DIRECTED [20] = '{
		'{CMD_NONE,   4'hF, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 0},
		'{CMD_HEADER, 4'd0, 4'd0, 32'h0000_1000, 16'd4, 4'd2, 0, 0, 0, 1'b0, 1'b0, 0},
		'{CMD_BOUNDS, 4'd0, 4'd0, 0, 0, 0, 32'd0, 32'd9, 0, 1'b0, 1'b0, 0},
		'{CMD_BOUNDS, 4'd0, 4'd1, 0, 0, 0, 32'd0, 32'd9, 0, 1'b0, 1'b0, 0},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd0, 1'b0, 1'b0, 0},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd0, 1'b1, 1'b1, 32'h0000_1000},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd3, 1'b0, 1'b0, 0},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd5, 1'b1, 1'b1, 32'h0000_108C},
		// dimension out of range, dropped
		'{CMD_BOUNDS, 4'd0, 4'd12, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
			1'b0, 1'b0, 0},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, 1'b0, 0},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd0, 1'b1, 1'b1, 32'h0000_0FD8},
		'{CMD_HEADER, 4'd15, 4'd0, 32'h8000_0000, 16'hFFFF, 4'd10, 0, 0, 0,
			1'b0, 1'b0, 0},
		'{CMD_BOUNDS, 4'd15, 4'd0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
			1'b0, 1'b0, 0},
		'{CMD_REF,    4'd15, 4'd0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1'b1, 1'b1,
			32'h7FFF_0001},
		// descriptor writes in the middle of a reference, then an id switch
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd1, 1'b0, 1'b0, 0},
		'{CMD_HEADER, 4'd3, 4'd0, 32'h0000_2000, 16'd8, 4'd1, 0, 0, 0, 1'b0, 1'b0, 0},
		'{CMD_BOUNDS, 4'd3, 4'd0, 0, 0, 0, 32'hFFFF_FFFB, 32'd5, 0, 1'b0, 1'b0, 0},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd2, 1'b1, 1'b0, 0},
		'{CMD_REF,    4'd3, 4'd0, 0, 0, 0, 0, 0, 32'hFFFF_FFFB, 1'b0, 1'b0, 0},
		'{CMD_REF,    4'd0, 4'd0, 0, 0, 0, 0, 0, 32'd9, 1'b1, 1'b0, 0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = CMD_NONE;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	map_row_t    rows [$];
	addr_exp_t   pending_addrs [$];
	int          n_work;
	int          n_acc;
	int          sent;
	int          fails;
	int          cycles;
	int          phase = PH_CALM;
	bit          squeezed;

	// shadow descriptor tables and running reference
	logic [31:0] tbl_base [N_ARR];
	logic [15:0] tbl_size [N_ARR];
	logic [3:0]  tbl_dims [N_ARR];
	logic [31:0] tbl_lower [N_ARR*N_DIMS];
	logic [31:0] tbl_extent [N_ARR*N_DIMS];
	logic [31:0] run_offset;
	int unsigned run_dim;

	bit          fired;
	addr_exp_t   predicted;
	addr_exp_t   oldest;

	multidim_array_address_mapper_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void map_item(input map_row_t r, output bit done, output addr_exp_t res);
		int unsigned slot;
		done = 1'b0;
		res = '0;
		case (r.cmd)
			CMD_HEADER: begin
				tbl_base[r.id] = r.base;
				tbl_size[r.id] = r.size;
				tbl_dims[r.id] = r.ndims;
			end
			CMD_BOUNDS: begin
				if (r.dpos < N_DIMS) begin
					slot = r.id * N_DIMS + r.dpos;
					tbl_lower[slot] = r.lo;
					tbl_extent[slot] = r.hi - r.lo + 32'd1;
				end
			end
			CMD_REF: begin
				slot = r.id * N_DIMS + run_dim;
				run_offset = run_offset * tbl_extent[slot] + (r.idx - tbl_lower[slot]);
				if (r.last) begin
					done = 1'b1;
					res.addr = tbl_base[r.id] + tbl_size[r.id] * run_offset;
					res.arr = r.id;
					run_offset = '0;
					run_dim = 0;
				end else if (run_dim < N_DIMS - 1) begin
					run_dim++;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $urandom_range(0, 40) - 20;
		endcase
	endfunction

	// unused fields carry random bits
	function automatic map_row_t rand_row(amap_cmd_t c, logic [3:0] id);
		map_row_t r;
		r.cmd = c;
		r.id = id;
		r.dpos = 4'($urandom);
		r.base = $urandom;
		r.size = 16'($urandom);
		r.ndims = 4'($urandom);
		r.lo = $urandom;
		r.hi = $urandom;
		r.idx = $urandom;
		r.last = 1'($urandom);
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic void add_row(map_row_t r);
		rows.insert(rows.size(), r);
		if (r.cmd != CMD_NONE && !(r.cmd == CMD_BOUNDS && r.dpos >= N_DIMS))
			n_work++;
	endfunction

	function automatic void add_header(logic [3:0] id);
		map_row_t r;
		r = rand_row(CMD_HEADER, id);
		r.base = rand_word();
		r.size = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 16));
		r.ndims = 4'($urandom_range(1, N_DIMS));
		add_row(r);
	endfunction

	function automatic void add_bounds(logic [3:0] id, int d);
		map_row_t r;
		r = rand_row(CMD_BOUNDS, id);
		r.dpos = 4'(d);
		if ($urandom_range(0, 4) == 0) begin
			r.lo = rand_word();
			r.hi = rand_word();
		end else begin
			r.lo = $urandom_range(0, 16) - 8;
			r.hi = r.lo + $urandom_range(0, 15);
		end
		add_row(r);
	endfunction

	function automatic void add_index(logic [3:0] id, bit last);
		map_row_t r;
		r = rand_row(CMD_REF, id);
		r.idx = ($urandom_range(0, 3) == 0) ? rand_word() : 32'($urandom_range(0, 24) - 8);
		r.last = last;
		add_row(r);
	endfunction

	// input side: predict on every accepted item
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			map_item(rows[n_acc], fired, predicted);
			if (fired) begin
				if (rows[n_acc].typed)
					predicted.addr = rows[n_acc].want;
				pending_addrs.insert(pending_addrs.size(), predicted);
			end
			n_acc++;
		end
	end

	// output side
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_addrs.size() == 0) begin
				$display("%0t: unexpected result, phys_addr %h ref_array %0d", $time,
					m_axis_tdata[31:0], m_axis_tdata[35:32]);
				fails++;
			end else begin
				oldest = pending_addrs.pop_front();
				if (m_axis_tdata[31:0] !== oldest.addr) begin
					$display("%0t: phys_addr expected %h, got %h", $time, oldest.addr,
						m_axis_tdata[31:0]);
					fails++;
				end
				if (m_axis_tdata[35:32] !== oldest.arr) begin
					$display("%0t: ref_array expected %0d, got %0d", $time, oldest.arr,
						m_axis_tdata[35:32]);
					fails++;
				end
			end
		end
	end

	// receiver
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (phase == PH_SQUEEZE && !squeezed) begin
				m_axis_tready <= 1'b0;
				repeat (SQUEEZE_CYC) @(posedge clk);
				squeezed = 1'b1;
			end else begin
				m_axis_tready <= !((phase == PH_SINK && $urandom_range(0, 99) < 81) ||
					(phase == PH_BOTH && $urandom_range(0, 99) < 31));
			end
		end
	end

	initial begin
		while (cycles < LIMIT_CYC) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned start;
		int          pick;
		int          len;
		logic [3:0]  cur;

		foreach (DIRECTED[k])
			add_row(DIRECTED[k]);

		// fill every descriptor before any random reference
		start = $urandom_range(0, N_ARR - 1);
		for (int k = 0; k < N_ARR; k++) begin
			add_header(4'(start + k));
			for (int d = 0; d < N_DIMS; d++)
				add_bounds(4'(start + k), d);
		end

		while (n_work < ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				cur = 4'($urandom);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(N_DIMS + 1, N_DIMS + 4)
					: $urandom_range(1, N_DIMS);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0)
						cur = 4'($urandom);
					if ($urandom_range(0, 11) == 0) begin
						if ($urandom_range(0, 1))
							add_header(4'($urandom));
						else
							add_bounds(4'($urandom), $urandom_range(0, N_DIMS - 1));
					end
					add_index(cur, k == len - 1);
				end
			end else if (pick < 80) begin
				cur = 4'($urandom);
				add_header(cur);
				repeat ($urandom_range(1, N_DIMS))
					add_bounds(cur, $urandom_range(0, N_DIMS - 1));
			end else if (pick < 90) begin
				add_row(rand_row(CMD_NONE, 4'($urandom)));
			end else begin
				add_bounds(4'($urandom), $urandom_range(N_DIMS, 15));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (sent < rows.size()) begin
			case (sent * 10 / rows.size())
				2, 3: phase = PH_SRC_IDLE;
				4, 5: phase = PH_SINK;
				6, 7: phase = PH_BOTH;
				9: phase = PH_SQUEEZE;
				default: phase = PH_CALM;
			endcase
			if ((phase == PH_SRC_IDLE && $urandom_range(0, 99) < 81) ||
				(phase == PH_BOTH && $urandom_range(0, 99) < 31)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'b0, rows[sent].idx, rows[sent].hi, rows[sent].lo,
					rows[sent].ndims, rows[sent].size, rows[sent].base, rows[sent].dpos,
					rows[sent].id};
				s_axis_tuser <= rows[sent].cmd;
				s_axis_tlast <= rows[sent].last;
			end
			do @(posedge clk); while (s_axis_tvalid && !s_axis_tready);
			if (s_axis_tvalid)
				sent++;
		end
		s_axis_tvalid <= 1'b0;
		phase = PH_CALM;

		while (pending_addrs.size() != 0 || n_acc < rows.size())
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
rtl/amap_pkg.sv
rtl/amap_tables.sv
rtl/multidim_array_address_mapper_core.sv
dv/tb_multidim_array_address_mapper_core.sv
